// File: hdl/rfr_pkg.sv
// Shared types and constants for the RPC frame receiver.
`default_nettype none

package rfr_pkg;

	// Header: three length bytes, then one header sum byte
	localparam logic [23:0] HDR_LEN_BYTES = 24'd3;
	localparam logic [7:0]  HDR_SUM_MASK  = 8'hff;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_HDR_OK,
		ST_HDR_ERR,
		ST_FRAME_OK,
		ST_FRAME_ERR
	} status_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        payload_last;
		status_t     frame_status;
		logic [23:0] frame_length;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/rpc_frame_receiver.sv
// Top level of the RPC frame receiver: input register, parser, result register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  rx       | rx_valid / rx_stall      | rx_byte
//  result   | res_valid / res_stall    | payload_byte, payload_valid,
//           |                          | payload_last, frame_status, frame_length
//  config   | cfg_valid / cfg_ready    | start_code
//
// One byte per cycle sustained while res_stall stays low; each byte gives exactly one result item.
// The byte is registered, decoded combinationally by the parser and its result
// registered at the output.
// Reset clears the frame state, the start code window and the start code.
// A stalled result holds the output register; the input register still takes
// a byte while it is empty, then stall propagates back to rx.
`default_nettype none

module rpc_frame_receiver
	import rfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [7:0]       payload_byte,
	output logic             payload_valid,
	output logic             payload_last,
	output logic [2:0]       frame_status,
	output logic [23:0]      frame_length,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] start_code
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res_comb;
	logic [31:0] start_code_q;
	logic        out_free;
	logic        step;
	logic        load_s1;

	// Pipeline control
	assign out_free  = !valid_s2 || !res_stall;
	assign step      = valid_s1 && out_free;
	assign load_s1   = !valid_s1 || out_free;
	assign rx_stall  = !load_s1;
	assign cfg_ready = 1'b1;

	// Hold the start code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			start_code_q <= 32'h0;
		else if (cfg_valid && cfg_ready)
			start_code_q <= start_code;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_s1)
			valid_s1 <= rx_valid;
	end

	always_ff @(posedge clk) begin
		if (load_s1 && rx_valid)
			byte_s1 <= rx_byte;
	end

	rfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (byte_s1),
		.start_code (start_code_q),
		.res        (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (out_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res_comb;
	end

	// Drive result ports
	assign res_valid     = valid_s2;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_valid = res_s2.payload_valid;
	assign payload_last  = res_s2.payload_last;
	assign frame_status  = res_s2.frame_status;
	assign frame_length  = res_s2.frame_length;

`ifndef SYNTHESIS
	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && payload_last |-> payload_valid)
		else $error("payload_last without payload_valid");

	a_length_only_hdr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (frame_length != 24'd0) |-> (frame_status == ST_HDR_OK))
		else $error("frame_length set outside header ok");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && valid_s2 && res_stall)
		else $error("rx stalled with room in the pipeline");

	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> res_valid)
		else $error("parsed item did not reach the result register");
`endif

endmodule

`default_nettype wire

// File: hdl/rfr_parser.sv
// Frame parser: start code hunt, header decode, payload sum and checksum compare.
`default_nettype none

module rfr_parser
	import rfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [31:0] start_code,
	output result_t          res
);

	phase_t      phase_q, phase_d;
	logic [31:0] window_q, window_d;
	logic [23:0] count_q, count_d;
	logic [23:0] length_q, length_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  sum_low_q, sum_low_d;

	logic [31:0] window_shift;
	logic        code_match;
	logic        hdr_sum_bad;
	logic [23:0] count_inc;
	logic        payload_end;
	logic [15:0] expect_sum;
	logic [15:0] got_sum;
	logic [23:0] length_ins;

	// Shared decode terms
	always_comb begin
		window_shift = {rx_byte, window_q[31:8]};
		code_match   = (window_shift == start_code);
		hdr_sum_bad  = ((sum_q & {8'h00, HDR_SUM_MASK}) != {8'h00, rx_byte});
		count_inc    = count_q + 24'd1;
		payload_end  = (count_inc == length_q);
		expect_sum   = sum_q + length_q[15:0];
		got_sum      = {rx_byte, sum_low_q};
		case (count_q[1:0])
			2'd0:    length_ins = {16'h0000, rx_byte};
			2'd1:    length_ins = {8'h00, rx_byte, 8'h00};
			2'd2:    length_ins = {rx_byte, 16'h0000};
			default: length_ins = 24'h000000;
		endcase
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT: begin
				if (code_match)
					phase_d = PH_HEADER;
			end
			PH_HEADER: begin
				if (count_q >= HDR_LEN_BYTES) begin
					if (hdr_sum_bad)
						phase_d = PH_HUNT;
					else if (length_q == 24'd0)
						phase_d = PH_CHECK;
					else
						phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (payload_end)
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				if (count_q != 24'd0)
					phase_d = PH_HUNT;
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	// Datapath updates and result for the byte in hand
	always_comb begin
		window_d  = window_q;
		count_d   = count_q;
		length_d  = length_q;
		sum_d     = sum_q;
		sum_low_d = sum_low_q;
		res       = '{8'h00, 1'b0, 1'b0, ST_IDLE, 24'h000000};
		case (phase_q)
			PH_HUNT: begin
				window_d = window_shift;
				if (code_match) begin
					count_d          = 24'd0;
					sum_d            = 16'd0;
					length_d         = 24'd0;
					res.frame_status = ST_START;
				end
			end
			PH_HEADER: begin
				if (count_q < HDR_LEN_BYTES) begin
					length_d = length_q | length_ins;
					sum_d    = sum_q + {8'h00, rx_byte};
					count_d  = count_inc;
				end else if (hdr_sum_bad) begin
					res.frame_status = ST_HDR_ERR;
				end else begin
					res.frame_status = ST_HDR_OK;
					res.frame_length = length_q;
					sum_d            = 16'd0;
					count_d          = 24'd0;
				end
			end
			PH_PAYLOAD: begin
				res.payload_byte  = rx_byte;
				res.payload_valid = 1'b1;
				sum_d             = sum_q + {8'h00, rx_byte};
				count_d           = count_inc;
				if (payload_end) begin
					res.payload_last = 1'b1;
					count_d          = 24'd0;
				end
			end
			PH_CHECK: begin
				if (count_q == 24'd0) begin
					sum_low_d = rx_byte;
					count_d   = 24'd1;
				end else begin
					res.frame_status = (expect_sum == got_sum) ? ST_FRAME_OK : ST_FRAME_ERR;
					sum_d            = expect_sum;
				end
			end
			default: ;
		endcase
	end

	// Advance state once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			window_q  <= 32'h0;
			count_q   <= 24'h0;
			length_q  <= 24'h0;
			sum_q     <= 16'h0;
			sum_low_q <= 8'h0;
		end else if (step) begin
			phase_q   <= phase_d;
			window_q  <= window_d;
			count_q   <= count_d;
			length_q  <= length_d;
			sum_q     <= sum_d;
			sum_low_q <= sum_low_d;
		end
	end

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for the RPC frame receiver: random framed byte streams checked against a parser model.
`default_nettype none

module tb
	import rfr_pkg::*;
;

	typedef enum int {
		FR_GOOD,
		FR_BAD_HDR,
		FR_BAD_SUM,
		FR_CUT
	} frame_kind_t;

	logic        clk;
	logic        arst_n;
	logic        rx_valid;
	wire logic   rx_stall;
	logic [7:0]  rx_byte;
	wire logic   res_valid;
	logic        res_stall;
	wire logic [7:0]  payload_byte;
	wire logic        payload_valid;
	wire logic        payload_last;
	wire logic [2:0]  frame_status;
	wire logic [23:0] frame_length;
	logic        cfg_valid;
	wire logic   cfg_ready;
	logic [31:0] start_code;

	rpc_frame_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.payload_byte  (payload_byte),
		.payload_valid (payload_valid),
		.payload_last  (payload_last),
		.frame_status  (frame_status),
		.frame_length  (frame_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.start_code    (start_code)
	);

	// Parser model state
	logic [31:0] code_reg;
	logic [31:0] hunt_window;
	phase_t      frame_phase;
	logic [23:0] byte_idx;
	logic [23:0] frame_len;
	logic [15:0] frame_sum;
	logic [7:0]  check_lo;

	result_t expected_results[$];

	int n_errors;
	int n_items;
	int n_results;
	int n_frames;
	int n_codes;
	int n_good;
	int n_sum_err;
	int n_hdr_err;
	bit quiet;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// Advance the parser model by one received byte and return its result item
	function automatic result_t parse_rx_byte(input logic [7:0] b);
		result_t r;
		logic [15:0] want;
		logic [15:0] got;
		r = '0;
		r.frame_status = ST_IDLE;
		case (frame_phase)
			PH_HUNT: begin
				hunt_window = {b, hunt_window[31:8]};
				if (hunt_window == code_reg) begin
					byte_idx = '0;
					frame_sum = '0;
					frame_len = '0;
					frame_phase = PH_HEADER;
					r.frame_status = ST_START;
				end
			end
			PH_HEADER: begin
				if (byte_idx < HDR_LEN_BYTES) begin
					frame_len = frame_len | (24'(b) << (8 * byte_idx));
					frame_sum = frame_sum + 16'(b);
					byte_idx = byte_idx + 24'd1;
				end else if ((frame_sum[7:0] & HDR_SUM_MASK) != b) begin
					r.frame_status = ST_HDR_ERR;
					frame_phase = PH_HUNT;
				end else begin
					r.frame_status = ST_HDR_OK;
					r.frame_length = frame_len;
					frame_sum = '0;
					byte_idx = '0;
					frame_phase = (frame_len == 24'd0) ? PH_CHECK : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				r.payload_byte = b;
				r.payload_valid = 1'b1;
				frame_sum = frame_sum + 16'(b);
				byte_idx = byte_idx + 24'd1;
				if (byte_idx == frame_len) begin
					r.payload_last = 1'b1;
					byte_idx = '0;
					frame_phase = PH_CHECK;
				end
			end
			default: begin
				if (byte_idx == 24'd0) begin
					check_lo = b;
					byte_idx = 24'd1;
				end else begin
					want = frame_sum + frame_len[15:0];
					got = {b, check_lo};
					r.frame_status = (want == got) ? ST_FRAME_OK : ST_FRAME_ERR;
					frame_sum = want;
					frame_phase = PH_HUNT;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on result %0d: %s got %0h want %0h", n_results, field, got, want);
		n_errors++;
	endtask

	// Hold a byte until it is taken, with random gaps ahead of it
	task automatic send_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			rx_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		expected_results.push_back(parse_rx_byte(b));
		n_items++;
	endtask

	task automatic drain_results;
		rx_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Write the start code once the block has gone idle
	task automatic write_code(input logic [31:0] code);
		drain_results();
		cfg_valid <= 1'b1;
		start_code <= code;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		code_reg = code;
		n_codes++;
	endtask

	// Send one frame: noise, start code, header, then payload and checksum per kind
	task automatic send_frame(input int unsigned len, input frame_kind_t kind);
		logic [7:0]  nb;
		logic [7:0]  hsum;
		logic [15:0] csum;
		logic [23:0] l;
		int unsigned cut;
		int unsigned i;
		l = 24'(len);
		// Noise never carries the first code byte, so the code cannot match early
		repeat ($urandom_range(3, 8)) begin
			do nb = 8'($urandom); while (nb == code_reg[7:0]);
			send_byte(nb);
		end
		for (i = 0; i < 4; i++) send_byte(code_reg[8 * i +: 8]);
		hsum = l[7:0] + l[15:8] + l[23:16];
		send_byte(l[7:0]);
		send_byte(l[15:8]);
		send_byte(l[23:16]);
		if (kind == FR_BAD_HDR) begin
			send_byte(hsum ^ 8'($urandom_range(1, 255)));
		end else begin
			send_byte(hsum);
			cut = (kind == FR_CUT) ? $urandom_range(1, len - 1) : len;
			csum = '0;
			for (i = 0; i < cut; i++) begin
				nb = 8'($urandom);
				csum = csum + 16'(nb);
				send_byte(nb);
			end
			if (kind != FR_CUT) begin
				csum = csum + l[15:0];
				if (kind == FR_BAD_SUM) csum = csum ^ 16'($urandom_range(1, 65535));
				send_byte(csum[7:0]);
				send_byte(csum[15:8]);
			end
		end
		n_frames++;
	endtask

	task automatic send_random_frame;
		int unsigned pick;
		int unsigned len;
		pick = $urandom_range(0, 15);
		if (pick == 0) len = 0;
		else if (pick == 1) len = $urandom_range(100, 300);
		else len = $urandom_range(1, 24);
		pick = $urandom_range(0, 99);
		if (pick < 70) send_frame(len, FR_GOOD);
		else if (pick < 80) send_frame(len, FR_BAD_HDR);
		else if (pick < 90) send_frame(len, FR_BAD_SUM);
		else send_frame($urandom_range(2, 24), FR_CUT);
	endtask

	// Zero code at reset, all-ones code, zero length, header and checksum errors
	task automatic test_directed;
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		write_code(32'hffff_ffff);
		send_byte(8'hff);
		send_byte(8'hff);
		send_byte(8'hff);
		send_byte(8'hff);
		send_byte(8'hff);
		send_byte(8'hff);
		send_byte(8'hff);
		send_byte(8'h02);
		write_code(32'h5aa5_3cc3);
		send_byte(8'hc3);
		send_byte(8'h3c);
		send_byte(8'ha5);
		send_byte(8'h5a);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h81);
		send_byte(8'h7f);
	endtask

	// Mostly well-formed frames with random content, start code changed now and then
	task automatic test_random_frames;
		int unsigned pick;
		while (n_items < 700) begin
			if (n_frames % 6 == 0) begin
				pick = $urandom_range(0, 5);
				if (pick == 0) write_code(32'h0000_0000);
				else if (pick == 1) write_code(32'hffff_ffff);
				else write_code($urandom);
			end
			send_random_frame();
		end
	endtask

	// Back-to-back stream with no idling on either side
	task automatic test_steady_stream;
		drain_results();
		quiet = 1'b1;
		while (n_items < 850) send_random_frame();
	endtask

	// Check each result item against the oldest expectation; drive random stall bursts
	initial begin
		result_t e;
		res_stall <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", {29'd0, frame_status}, 32'd0);
				end else begin
					e = expected_results.pop_front();
					if (payload_byte !== e.payload_byte)
						report_mismatch("payload_byte", 32'(payload_byte),
							32'(e.payload_byte));
					if (payload_valid !== e.payload_valid)
						report_mismatch("payload_valid", 32'(payload_valid),
							32'(e.payload_valid));
					if (payload_last !== e.payload_last)
						report_mismatch("payload_last", 32'(payload_last),
							32'(e.payload_last));
					if (frame_status !== e.frame_status)
						report_mismatch("frame_status", 32'(frame_status),
							32'(e.frame_status));
					if (frame_length !== e.frame_length)
						report_mismatch("frame_length", 32'(frame_length),
							32'(e.frame_length));
					if (e.frame_status == ST_FRAME_OK) n_good++;
					if (e.frame_status == ST_FRAME_ERR) n_sum_err++;
					if (e.frame_status == ST_HDR_ERR) n_hdr_err++;
				end
				n_results++;
			end
			if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				res_stall <= 1'b1;
				stall_left = $urandom_range(0, 10);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		n_errors = 0;
		n_items = 0;
		n_results = 0;
		n_frames = 0;
		n_codes = 0;
		n_good = 0;
		n_sum_err = 0;
		n_hdr_err = 0;
		quiet = 1'b0;
		code_reg = '0;
		hunt_window = '0;
		frame_phase = PH_HUNT;
		byte_idx = '0;
		frame_len = '0;
		frame_sum = '0;
		check_lo = '0;
		arst_n <= 1'b0;
		rx_valid <= 1'b0;
		rx_byte <= 8'h00;
		cfg_valid <= 1'b0;
		start_code <= 32'h0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames();
		test_steady_stream();

		drain_results();
		repeat (10) @(posedge clk);
		$display("sent %0d bytes in %0d generated frames under %0d start code writes",
			n_items, n_frames, n_codes);
		$display("checked %0d results: %0d frames good, %0d checksum errors, %0d header errors",
			n_results, n_good, n_sum_err, n_hdr_err);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
hdl/rfr_pkg.sv
hdl/rfr_parser.sv
hdl/rpc_frame_receiver.sv
sim/tb.sv
